### rtl/wwsf_pkg.sv
// Package for the weight word to single float unit: format codes, field widths,
// a shared helper function. No dependencies.
package wwsf_pkg;

   localparam int WORD_W = 32;

   typedef enum logic [1:0] {
      FMT_SINGLE = 2'd0,
      FMT_HALF   = 2'd1,
      FMT_BYTE   = 2'd2,
      FMT_RSVD   = 2'd3
   } format_type;

   typedef enum logic {
      CSR_FORMAT = 1'b0,
      CSR_SCALE  = 1'b1
   } csr_index_type;

   localparam logic [31:0] QNAN_BITS  = 32'h7FC0_0000;
   localparam logic [31:0] INF_BITS   = 32'h7F80_0000;
   localparam logic [31:0] SCALE_INIT = 32'h3F80_0000;

   // Per-item context carried from the input stage to the output stage.
   typedef struct packed {
      format_type  fmt;
      logic [31:0] word;
      logic        sign;
      logic        special;
      logic [31:0] special_bits;
      logic [31:0] prod;
      logic signed [9:0] ebias;
   } stage_type;

   // Position of the leading one in a 32-bit value (0 when zero).
   function automatic logic [4:0] msb_pos(input logic [31:0] v);
      logic [4:0] pos;
      pos = '0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) pos = 5'(i);
      end
      return pos;
   endfunction

endpackage

### rtl/wwsf_half.sv
// Half to single widening, combinational; subnormal halves come out at half their value.
// Depends on wwsf_pkg.
module wwsf_half (
   input  logic [15:0] half_bits,
   output logic [31:0] single_bits
);
   logic        sign;
   logic [4:0]  ex;
   logic [9:0]  fr;
   logic [4:0]  lead;
   logic [3:0]  sh;
   logic [9:0]  norm;
   logic [7:0]  sub_exp;

   always_comb begin
      sign = half_bits[15];
      ex   = half_bits[14:10];
      fr   = half_bits[9:0];
      lead = wwsf_pkg::msb_pos({22'd0, fr});
      sh   = 4'(5'd10 - lead);
      norm = 10'(fr << sh);
      sub_exp = 8'(8'd112 - {4'd0, sh} + 8'd1);
      if (ex == 5'd0) begin
         if (fr == 10'd0) single_bits = {sign, 31'd0};
         else single_bits = {sign, sub_exp - 8'd1, norm, 13'd0};
      end else if (ex == 5'h1F) begin
         single_bits = {sign, 8'hFF, fr, 13'd0};
      end else begin
         single_bits = {sign, 8'({3'd0, ex} + 8'd112), fr, 13'd0};
      end
   end
endmodule

### rtl/wwsf_round.sv
// Normalize and round-to-nearest-even of the byte-times-scale product.
// Depends on wwsf_pkg.
module wwsf_round (
   input  logic [31:0]       prod,
   input  logic signed [9:0] ebias,
   input  logic              sign,
   output logic [31:0]       result
);
   logic [4:0]         msb;
   logic signed [10:0] be;
   logic signed [10:0] sh;
   logic [5:0]         rs;
   logic [31:0]        mant;
   logic [31:0]        rem;
   logic [31:0]        half;
   logic [24:0]        m2;
   logic signed [10:0] be2;

   always_comb begin
      msb = wwsf_pkg::msb_pos(prod);
      be  = 11'(signed'({6'd0, msb})) + 11'(ebias) - 11'sd23;
      if (be < 11'sd1) be = 11'sd1;
      sh  = be - 11'(ebias);
      mant = '0;
      rem  = '0;
      half = '0;
      if (sh > 11'sd0) begin
         rs   = (sh > 11'sd32) ? 6'd32 : 6'(sh);
         mant = (rs == 6'd32) ? 32'd0 : prod >> rs;
         rem  = (rs == 6'd32) ? prod : prod & ((32'd1 << rs) - 32'd1);
         half = 32'd1 << (rs - 6'd1);
         if (rem > half || (rem == half && mant[0])) mant = mant + 32'd1;
      end else begin
         rs   = 6'(-sh);
         mant = prod << rs;
      end
      m2  = mant[24:0];
      be2 = be;
      if (m2[24]) begin
         m2  = m2 >> 1;
         be2 = be + 11'sd1;
      end
      if (be2 >= 11'sd255) result = {sign, wwsf_pkg::INF_BITS[30:0]};
      else if (!m2[23]) result = {sign, 8'd0, m2[22:0]};
      else result = {sign, be2[7:0], m2[22:0]};
   end
endmodule

### rtl/weight_word_to_single_float_unit.sv
// Top level of the weight word to single float unit.
// Depends on wwsf_pkg, wwsf_half and wwsf_round.
//
// Decodes one raw weight word per transfer into an IEEE single bit pattern:
// pass-through (format 0 or 3), half widening (format 1) or signed byte
// times the scale register with round-to-nearest-even (format 2). One item per
// cycle sustained with a ready receiver: the input stage does the half decode and
// the 8x24 multiply, the output stage normalizes, rounds and holds the result.
// The output register doubles as the skid point: a new transfer is taken while
// a result waits as long as the output stage will drain in the same cycle.
// CSR writes only while idle; no read-back.
module weight_word_to_single_float_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] raw_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] weight_bits
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);
   logic [1:0]  fmt_ff;
   logic [31:0] scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff   <= wwsf_pkg::FMT_SINGLE;
         scale_ff <= wwsf_pkg::SCALE_INIT;
      end else if (csr_we) begin
         case (csr_index)
            wwsf_pkg::CSR_FORMAT: fmt_ff   <= csr_wdata[1:0];
            wwsf_pkg::CSR_SCALE:  scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 1 valid / stage 2 valid
   logic s1_valid_ff, s2_valid_ff;
   wwsf_pkg::stage_type s1_ff, s1_in;
   logic [31:0] s2_ff, s2_in;
   logic s2_load, s1_move;

   assign s2_load    = !s2_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && s2_load;
   assign req_tready = !s1_valid_ff || s2_load;

   // input-side decode
   logic [31:0] half_res;
   logic [7:0]  b;
   logic        bsign;
   logic [7:0]  mag;
   logic [7:0]  se;
   logic [22:0] sf;
   logic [23:0] m;

   wwsf_half u_half (.half_bits(req_tdata[15:0]), .single_bits(half_res));

   always_comb begin
      b     = req_tdata[7:0];
      bsign = b[7];
      mag   = bsign ? 8'(8'd0 - b) : b;
      se    = scale_ff[30:23];
      sf    = scale_ff[22:0];
      m     = (se != 8'd0) ? {1'b1, sf} : {1'b0, sf};
      s1_in.fmt  = wwsf_pkg::format_type'(fmt_ff);
      s1_in.word = (fmt_ff == wwsf_pkg::FMT_HALF) ? half_res : req_tdata;
      s1_in.sign = bsign ^ scale_ff[31];
      s1_in.special = 1'b0;
      s1_in.special_bits = {s1_in.sign, 31'd0};
      if (se == 8'hFF) begin
         s1_in.special = 1'b1;
         s1_in.special_bits = (sf != 23'd0 || b == 8'd0) ? wwsf_pkg::QNAN_BITS
                              : {s1_in.sign, wwsf_pkg::INF_BITS[30:0]};
      end else if (b == 8'd0 || (se == 8'd0 && sf == 23'd0)) begin
         s1_in.special = 1'b1;
      end
      // mag of 0x80 comes out as 0x80 (128) above; the select gives 128 as well
      s1_in.prod  = {8'd0, m} * {24'd0, (b == 8'h80) ? 8'd128 : mag};
      s1_in.ebias = (se != 8'd0) ? 10'(signed'({2'd0, se})) : 10'sd1;
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (req_tready) s1_valid_ff <= req_tvalid;
      if (req_tready && req_tvalid) s1_ff <= s1_in;
   end

   logic [31:0] rnd_res;
   wwsf_round u_round (
      .prod(s1_ff.prod), .ebias(s1_ff.ebias), .sign(s1_ff.sign), .result(rnd_res)
   );

   always_comb begin
      case (s1_ff.fmt)
         wwsf_pkg::FMT_BYTE: s2_in = s1_ff.special ? s1_ff.special_bits : rnd_res;
         default:            s2_in = s1_ff.word;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (s2_load) s2_valid_ff <= s1_valid_ff;
      if (s1_move) s2_ff <= s2_in;
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = s2_ff;
endmodule

### tb/tb_top.sv
// Testbench for weight_word_to_single_float_unit: directed and random words in
// all formats, checked against an in-bench decoder. Depends on wwsf_pkg.
`timescale 1ns / 100ps
module tb_top;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] raw_word
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] weight_bits
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [31:0] csr_wdata = '0;

   weight_word_to_single_float_unit dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // bench copy of the registers
   wwsf_pkg::format_type cur_fmt;
   logic [31:0] cur_scale;
   logic [31:0] expected_bits[$];
   int          mismatch_count = 0;
   int          send_idle_pct = 0;   // chance of a gap before each transfer
   int          recv_stall_pct = 0;  // chance of holding off each cycle
   bit          hold_off = 1'b0;     // long receiver stall in progress
   longint      cycle_count = 0;

   // widening of a half pattern; subnormals come out at half their value
   function automatic logic [31:0] widen_half(input logic [15:0] h);
      logic [31:0] sgn;
      logic [7:0]  ex;
      logic [9:0]  fr;
      sgn = {h[15], 31'b0};
      ex  = {3'b0, h[14:10]};
      fr  = h[9:0];
      if (ex == 8'd0) begin
         if (fr == 10'd0) return sgn;
         ex = 8'd112;
         while (!fr[9]) begin
            fr = fr << 1;
            ex = ex - 8'd1;
         end
         // leading one drops out when shifted once more
         return sgn | {1'b0, ex - 8'd1, fr[8:0], 14'b0};
      end
      if (ex == 8'h1F) return sgn | wwsf_pkg::INF_BITS | {9'b0, fr, 13'b0};
      return sgn | {1'b0, ex + 8'd112, fr, 13'b0};
   endfunction

   // signed byte times single scale, round to nearest even
   function automatic logic [31:0] scale_byte(input logic [7:0] b, input logic [31:0] sc);
      logic [8:0]  mag;
      logic [7:0]  e;
      logic [22:0] f;
      logic [31:0] sgn;
      logic [63:0] m, p, mant, rem, hlf;
      int          ebias, be, sh, msb;
      mag = b[7] ? (9'd256 - {1'b0, b}) : {1'b0, b};
      e = sc[30:23];
      f = sc[22:0];
      sgn = {b[7] ^ sc[31], 31'b0};
      if (e == 8'hFF) begin
         if (f != 0 || mag == 0) return wwsf_pkg::QNAN_BITS;
         return sgn | wwsf_pkg::INF_BITS;
      end
      if (mag == 0 || (e == 0 && f == 0)) return sgn;
      m = (e != 0) ? {40'b0, 1'b1, f} : {41'b0, f};
      ebias = (e != 0) ? int'(e) : 1;
      p = mag * m;
      msb = 0;
      while (msb < 40 && (p >> (msb + 1)) != 0) msb++;
      be = msb + ebias - 23;
      if (be < 1) be = 1;
      sh = be - ebias;
      if (sh > 0) begin
         rem = p & ((64'd1 << sh) - 1);
         hlf = 64'd1 << (sh - 1);
         mant = p >> sh;
         if (rem > hlf || (rem == hlf && mant[0])) mant++;
      end else
         mant = p << (-sh);
      if (mant >= (64'd1 << 24)) begin
         mant = mant >> 1;
         be++;
      end
      if (be >= 255) return sgn | wwsf_pkg::INF_BITS;
      if (mant < (64'd1 << 23)) return sgn | mant[31:0];
      return sgn | {1'b0, 8'(be), mant[22:0]};
   endfunction

   function automatic logic [31:0] decode_word(input logic [31:0] w);
      case (cur_fmt)
         wwsf_pkg::FMT_HALF: return widen_half(w[15:0]);
         wwsf_pkg::FMT_BYTE: return scale_byte(w[7:0], cur_scale);
         default:  return w;
      endcase
   endfunction

   // register write, only with the unit drained, after a margin
   task automatic write_csr(input wwsf_pkg::csr_index_type idx, input logic [31:0] val);
      req_tvalid <= 1'b0;
      wait (expected_bits.size() == 0);
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == wwsf_pkg::CSR_FORMAT) cur_fmt = wwsf_pkg::format_type'(val[1:0]);
      else cur_scale = val;
   endtask

   // one input transfer; expectation queued at acceptance, valid left high
   task automatic send_word(input logic [31:0] w);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_bits.push_back(decode_word(w));
   endtask

   // receiver readiness
   always @(posedge clock) begin
      rsp_tready <= !hold_off && !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
   end

   // result checker
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bits.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %h", rsp_tdata);
         end else begin
            logic [31:0] exp_bits;
            exp_bits = expected_bits.pop_front();
            if (rsp_tdata !== exp_bits) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("weight_bits mismatch: expected %h got %h", exp_bits, rsp_tdata);
            end
         end
      end
      if (cycle_count > 400000) begin
         $display("tb_top failed");
         $finish;
      end
   end

   function automatic logic [31:0] rand_word();
      return $urandom;
   endfunction

   // scales that hit zero, subnormal, huge, infinite and NaN cases
   function automatic logic [31:0] rand_scale();
      case ($urandom_range(7))
         0: return {1'($urandom_range(1)), 8'h00, 23'($urandom)};
         1: return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(1) ? 0 : $urandom)};
         2: return {1'($urandom_range(1)), 8'($urandom_range(245, 254)), 23'($urandom)};
         3: return {1'($urandom_range(1)), 8'($urandom_range(1, 10)), 23'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   task automatic test_pass_through();
      write_csr(wwsf_pkg::CSR_FORMAT, wwsf_pkg::FMT_SINGLE);
      send_word(32'h0000_0000);
      send_word(32'hFFFF_FFFF);
      send_word(32'h7FC0_0001);
      write_csr(wwsf_pkg::CSR_FORMAT, wwsf_pkg::FMT_RSVD);
      send_word(32'h8000_0000);
      send_word(32'h1234_5678);
   endtask

   task automatic test_half();
      write_csr(wwsf_pkg::CSR_FORMAT, wwsf_pkg::FMT_HALF);
      send_word(32'hABCD_0000);   // zero, upper junk
      send_word(32'h0000_8000);   // negative zero
      send_word(32'h0000_0001);   // smallest subnormal
      send_word(32'h0000_83FF);   // largest subnormal
      send_word(32'h0000_7C00);   // infinity
      send_word(32'h0000_FE01);   // NaN with payload
      send_word(32'h0000_7BFF);
      send_word(32'h0000_3C00);
   endtask

   task automatic test_byte();
      write_csr(wwsf_pkg::CSR_FORMAT, wwsf_pkg::FMT_BYTE);
      write_csr(wwsf_pkg::CSR_SCALE, 32'hBF80_0000);
      send_word(32'hFFFF_FF00);   // zero byte, sign from scale
      send_word(32'h0000_0080);
      send_word(32'h0000_007F);
      write_csr(wwsf_pkg::CSR_SCALE, wwsf_pkg::INF_BITS);
      send_word(32'h0000_0001);
      send_word(32'h0000_0000);   // zero times infinity
      write_csr(wwsf_pkg::CSR_SCALE, 32'h7F80_0001);
      send_word(32'h0000_0005);
      write_csr(wwsf_pkg::CSR_SCALE, 32'h7F7F_FFFF);   // overflow
      send_word(32'h0000_0080);
      write_csr(wwsf_pkg::CSR_SCALE, 32'h0000_0001);   // tiny results
      send_word(32'h0000_0003);
      write_csr(wwsf_pkg::CSR_SCALE, 32'h0000_0000);
      send_word(32'h0000_0011);
      write_csr(wwsf_pkg::CSR_SCALE, 32'hFFFF_FFFF);
      send_word(32'h0000_0011);
   endtask

   // random words, formats and scales under one idling pattern
   task automatic test_random(input int n, input int idle, input int stall);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      for (int i = 0; i < n; i++) begin
         if (i % 50 == 0) begin
            write_csr(wwsf_pkg::CSR_FORMAT, wwsf_pkg::format_type'($urandom_range(3)));
            write_csr(wwsf_pkg::CSR_SCALE, rand_scale());
         end
         send_word(rand_word());
      end
   endtask

   // receiver holds off long enough that the unit fills and stalls its input
   task automatic test_backpressure();
      int stall_cycles;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off = 1'b1;
      fork
         begin
            stall_cycles = 0;
            while (stall_cycles < 60) begin
               @(posedge clock);
               stall_cycles++;
            end
            hold_off = 1'b0;
         end
         for (int i = 0; i < 30; i++) send_word(rand_word());
      join
      req_tvalid <= 1'b0;
   endtask

   initial begin
      cur_fmt = wwsf_pkg::FMT_SINGLE;
      cur_scale = wwsf_pkg::SCALE_INIT;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_pass_through();
      test_half();
      test_byte();
      test_random(250, 0, 0);
      test_random(250, 50, 0);
      test_random(250, 0, 50);
      test_random(250, 35, 35);
      test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      wait (expected_bits.size() == 0);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_bits.size() == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end
endmodule
